/* src/ecd_pkg.sv */
package ecd_pkg;

  // Pipeline depth, input register through output register
  localparam int NumStages = 6;

  // Day split: secs[31:7] / 675 by reciprocal multiply
  localparam int DayShift = 34;
  localparam logic [24:0] DayRecip = 25'((64'd1 << DayShift) / 64'd675);
  localparam logic [9:0] SecsPerDayOdd = 10'd675;

  // Calendar constants
  localparam logic [15:0] DaysFrom1968 = 16'(365 + 366);
  localparam logic [10:0] DaysPerQuad = 11'd1461;
  localparam logic [7:0] YearBaseOffset = 8'(1968 - 1900);

  // Reciprocals for the constant divides (MinRecip over 2**10, rest 2**16)
  localparam logic [5:0] QuadRecip = 6'((1 << 16) / 1461);
  localparam logic [13:0] WeekRecip = 14'((1 << 16) / 7);
  localparam logic [8:0] HourRecip = 9'((1 << 16) / 225);
  localparam logic [6:0] MinRecip = 7'((1 << 10) / 15);

  // Cumulative month start, non-leap
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] v;
    case (m)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd365;
    endcase
    return v;
  endfunction

  // Month threshold, one day later from March on in a leap year
  function automatic logic [8:0] month_thr(input logic [3:0] m, input logic leap);
    return month_start(m) + 9'((leap && (m >= 4'd2)) ? 1 : 0);
  endfunction

endpackage

/* src/ecd_day_split.sv */
module ecd_day_split (
  input  logic                           clk_i,
  input  logic [ecd_pkg::NumStages-1:0]  adv_i,
  input  logic [31:0]                    epoch_seconds_i,
  output logic [15:0]                    days_o,
  output logic [16:0]                    sec_of_day_o
);

  logic [31:0] secs_q;
  logic [15:0] qest_q;
  logic [15:0] days_q, days_d;
  logic [16:0] sod_q, sod_d;

  logic [49:0] prod_w;
  logic [25:0] sub_w;
  logic [10:0] r_w;
  logic [9:0]  rr_w;

  // Stage 0: estimate of secs / 86400, low by at most one
  assign prod_w = 50'(epoch_seconds_i[31:7]) * 50'(ecd_pkg::DayRecip);

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      secs_q <= epoch_seconds_i;
      qest_q <= prod_w[49:ecd_pkg::DayShift];
    end
  end

  // Stage 1: correct the estimate and rebuild seconds of day
  always_comb begin
    sub_w = 26'(secs_q[31:7]) - 26'(qest_q) * 26'(ecd_pkg::SecsPerDayOdd);
    r_w   = sub_w[10:0];
    if (r_w >= 11'(ecd_pkg::SecsPerDayOdd)) begin
      days_d = qest_q + 16'd1;
      rr_w   = 10'(r_w - 11'(ecd_pkg::SecsPerDayOdd));
    end else begin
      days_d = qest_q;
      rr_w   = r_w[9:0];
    end
    sod_d = {rr_w, secs_q[6:0]};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      days_q <= days_d;
      sod_q  <= sod_d;
    end
  end

  assign days_o       = days_q;
  assign sec_of_day_o = sod_q;

endmodule

/* src/ecd_clock.sv */
module ecd_clock (
  input  logic                           clk_i,
  input  logic [ecd_pkg::NumStages-1:0]  adv_i,
  input  logic [16:0]                    sec_of_day_i,
  output logic [5:0]                     second_of_minute_o,
  output logic [5:0]                     minute_of_hour_o,
  output logic [4:0]                     hour_of_day_o
);

  logic [16:0] sod_q;
  logic [4:0]  hest_q;
  logic [11:0] rem2_q, rem2_d;
  logic [4:0]  hrs_q, hrs_d;
  logic [11:0] rem2b_q;
  logic [4:0]  hrsb_q;
  logic [5:0]  mest_q;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hrso_q;

  logic [21:0] hprod_w;
  logic [16:0] hsub_w;
  logic [16:0] mprod_w;
  logic [11:0] msub_w;

  // Stage 2: hour estimate, (sod / 16) / 225
  assign hprod_w = 22'(sec_of_day_i[16:4]) * 22'(ecd_pkg::HourRecip);

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      sod_q  <= sec_of_day_i;
      hest_q <= hprod_w[20:16];
    end
  end

  // Stage 3: correct hour, remainder within the hour
  always_comb begin
    hsub_w = sod_q - 17'(hest_q) * 17'd3600;
    if (hsub_w >= 17'd3600) begin
      hrs_d  = hest_q + 5'd1;
      rem2_d = 12'(hsub_w - 17'd3600);
    end else begin
      hrs_d  = hest_q;
      rem2_d = hsub_w[11:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[3]) begin
      rem2_q <= rem2_d;
      hrs_q  <= hrs_d;
    end
  end

  // Stage 4: minute estimate, (rem / 4) / 15
  assign mprod_w = 17'(rem2_q[11:2]) * 17'(ecd_pkg::MinRecip);

  always_ff @(posedge clk_i) begin
    if (adv_i[4]) begin
      rem2b_q <= rem2_q;
      hrsb_q  <= hrs_q;
      mest_q  <= mprod_w[15:10];
    end
  end

  // Stage 5: correct minute, seconds remainder
  always_comb begin
    msub_w = rem2b_q - 12'(mest_q) * 12'd60;
    if (msub_w >= 12'd60) begin
      min_d = mest_q + 6'd1;
      sec_d = 6'(msub_w - 12'd60);
    end else begin
      min_d = mest_q;
      sec_d = msub_w[5:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[5]) begin
      sec_q  <= sec_d;
      min_q  <= min_d;
      hrso_q <= hrsb_q;
    end
  end

  assign second_of_minute_o = sec_q;
  assign minute_of_hour_o   = min_q;
  assign hour_of_day_o      = hrso_q;

endmodule

/* src/ecd_date.sv */
module ecd_date (
  input  logic                           clk_i,
  input  logic [ecd_pkg::NumStages-1:0]  adv_i,
  input  logic [15:0]                    days_i,
  output logic [4:0]                     day_of_month_o,
  output logic [3:0]                     month_index_o,
  output logic [7:0]                     years_since_1900_o,
  output logic [2:0]                     weekday_o,
  output logic [8:0]                     day_of_year_o
);

  logic [15:0] iday_w, wk_w;
  logic [21:0] qprod_w;
  logic [29:0] wprod_w;

  logic [15:0] iday_q, wk_q;
  logic [5:0]  qest_q;
  logic [12:0] west_q;

  logic [15:0] qsub_w, wsub_w;
  logic [5:0]  quad_q, quad_d;
  logic [10:0] qday_q, qday_d;
  logic [2:0]  wday_q, wday_d;

  logic [10:0] t_w;
  logic [1:0]  yoff_w;
  logic [8:0]  jday_d, jday_q;
  logic        leap_d, leap_q;
  logic [7:0]  yrs_d, yrs_q;
  logic [2:0]  wdayb_q;

  logic [3:0]  mon_w;
  logic [8:0]  thr_w;
  logic [4:0]  mday_w;
  logic [4:0]  mday_q;
  logic [3:0]  mon_q;
  logic [7:0]  yrso_q;
  logic [2:0]  wdayo_q;
  logic [8:0]  jdayo_q;

  // Stage 2: days from 1968, quad and week estimates
  assign iday_w  = days_i + ecd_pkg::DaysFrom1968;
  assign wk_w    = days_i + 16'd4;
  assign qprod_w = 22'(iday_w) * 22'(ecd_pkg::QuadRecip);
  assign wprod_w = 30'(wk_w) * 30'(ecd_pkg::WeekRecip);

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      iday_q <= iday_w;
      wk_q   <= wk_w;
      qest_q <= qprod_w[21:16];
      west_q <= wprod_w[28:16];
    end
  end

  // Stage 3: correct quad and weekday
  always_comb begin
    qsub_w = iday_q - 16'(qest_q) * 16'(ecd_pkg::DaysPerQuad);
    if (qsub_w >= 16'(ecd_pkg::DaysPerQuad)) begin
      quad_d = qest_q + 6'd1;
      qday_d = 11'(qsub_w - 16'(ecd_pkg::DaysPerQuad));
    end else begin
      quad_d = qest_q;
      qday_d = qsub_w[10:0];
    end
    wsub_w = wk_q - 16'(west_q) * 16'd7;
    if (wsub_w >= 16'd7) begin
      wday_d = 3'(wsub_w - 16'd7);
    end else begin
      wday_d = wsub_w[2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[3]) begin
      quad_q <= quad_d;
      qday_q <= qday_d;
      wday_q <= wday_d;
    end
  end

  // Stage 4: year within the quad, leap flag, day of year
  always_comb begin
    t_w = qday_q - 11'd366;
    if (qday_q < 11'd366) begin
      yoff_w = 2'd0;
      jday_d = qday_q[8:0];
      leap_d = 1'b1;
    end else if (t_w >= 11'd730) begin
      yoff_w = 2'd3;
      jday_d = 9'(t_w - 11'd730);
      leap_d = 1'b0;
    end else if (t_w >= 11'd365) begin
      yoff_w = 2'd2;
      jday_d = 9'(t_w - 11'd365);
      leap_d = 1'b0;
    end else begin
      yoff_w = 2'd1;
      jday_d = t_w[8:0];
      leap_d = 1'b0;
    end
    yrs_d = ecd_pkg::YearBaseOffset + {quad_q, 2'b00} + 8'(yoff_w);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[4]) begin
      jday_q  <= jday_d;
      leap_q  <= leap_d;
      yrs_q   <= yrs_d;
      wdayb_q <= wday_q;
    end
  end

  // Stage 5: month search over thresholds, day of month
  always_comb begin
    mon_w = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (jday_q >= ecd_pkg::month_thr(4'(m), leap_q)) begin
        mon_w = 4'(m);
      end
    end
    thr_w  = ecd_pkg::month_thr(mon_w, leap_q);
    mday_w = 5'(jday_q - thr_w + 9'd1);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[5]) begin
      mday_q  <= mday_w;
      mon_q   <= mon_w;
      yrso_q  <= yrs_q;
      wdayo_q <= wdayb_q;
      jdayo_q <= jday_q;
    end
  end

  assign day_of_month_o     = mday_q;
  assign month_index_o      = mon_q;
  assign years_since_1900_o = yrso_q;
  assign weekday_o          = wdayo_q;
  assign day_of_year_o      = jdayo_q;

endmodule

/* src/epoch_seconds_to_calendar_date.sv */
// Converts unsigned seconds since 1970-01-01 00:00:00 UTC into a UTC calendar
// date and time of day: second, minute, hour, day of month, zero-based month,
// years since 1900, weekday (0 = Sunday) and zero-based day of year. Leap years
// follow the every-fourth-year rule, which is correct through the end of 2099;
// later inputs keep that rule (2100 counts as leap). The block is a six-stage
// pipeline that takes one beat per cycle while the output is not held off;
// the stages are the day split multiplier, its correction, and four stages
// of constant divides and the month threshold search. A stall holds every
// stage that cannot move; empty stages still fill, so bubbles close up.
module epoch_seconds_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  second_of_minute_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [4:0]  hour_of_day_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_index_o,
  output logic [7:0]  years_since_1900_o,
  output logic [2:0]  weekday_o,
  output logic [8:0]  day_of_year_o
);

  localparam int Last = ecd_pkg::NumStages - 1;

  logic [ecd_pkg::NumStages-1:0] vld_q;
  logic [ecd_pkg::NumStages-1:0] adv_w;
  logic [15:0]                   days_w;
  logic [16:0]                   sod_w;

  // Stage i may load when it is empty or its beat moves on
  always_comb begin
    adv_w[Last] = !vld_q[Last] || out_ready_i;
    for (int i = Last - 1; i >= 0; i--) begin
      adv_w[i] = !vld_q[i] || adv_w[i+1];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv_w[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < ecd_pkg::NumStages; i++) begin
        if (adv_w[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  assign in_ready_o  = adv_w[0];
  assign out_valid_o = vld_q[Last];

  ecd_day_split u_day_split (
    .clk_i           (clk_i),
    .adv_i           (adv_w),
    .epoch_seconds_i (epoch_seconds_i),
    .days_o          (days_w),
    .sec_of_day_o    (sod_w)
  );

  ecd_clock u_clock (
    .clk_i              (clk_i),
    .adv_i              (adv_w),
    .sec_of_day_i       (sod_w),
    .second_of_minute_o (second_of_minute_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .hour_of_day_o      (hour_of_day_o)
  );

  ecd_date u_date (
    .clk_i              (clk_i),
    .adv_i              (adv_w),
    .days_i             (days_w),
    .day_of_month_o     (day_of_month_o),
    .month_index_o      (month_index_o),
    .years_since_1900_o (years_since_1900_o),
    .weekday_o          (weekday_o),
    .day_of_year_o      (day_of_year_o)
  );

endmodule
